[src/pps_pkg.sv]
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Widths, codes and shared types of the scheduler, its slot memory and its
// sequencer.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int SLOTS   = 16;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SLOT_W  = 4;
   localparam int BURST_W = 8;
   localparam int TIME_W  = 16;
   localparam int PRIO_W  = 8;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);

   // Request command codes.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [BURST_W-1:0] remaining;
      logic [BURST_W-1:0] orig_burst;
      logic [TIME_W-1:0]  arrive;
      logic [PRIO_W-1:0]  prio;
   } slot_entry_type;

   typedef struct packed {
      logic           wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_entry_type wr_data;
      logic           rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_now;
      logic [SLOT_W-1:0] selected;
      logic              idle;
      logic              finished;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

[src/pps_req_if.sv]
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one load or tick request.
// ----------------------------------------------------------------------------
interface pps_req_if import pps_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                command;
   logic [SLOT_W-1:0]   slot;
   logic [BURST_W-1:0]  burst;
   logic [TIME_W-1:0]   arrival;
   logic [PRIO_W-1:0]   priority_req;

   modport source (output valid, command, slot, burst, arrival, priority_req,
                   input ready);
   modport sink   (input valid, command, slot, burst, arrival, priority_req,
                   output ready);
endinterface

[src/pps_rsp_if.sv]
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying the result of one request.
// ----------------------------------------------------------------------------
interface pps_rsp_if import pps_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_now;
   logic [SLOT_W-1:0] selected;
   logic              idle;
   logic              finished;
   logic [TIME_W-1:0] completion;
   logic [TIME_W-1:0] turnaround;
   logic [TIME_W-1:0] waiting;

   modport source (output valid, time_now, selected, idle, finished, completion,
                   turnaround, waiting,
                   input ready);
   modport sink   (input valid, time_now, selected, idle, finished, completion,
                   turnaround, waiting,
                   output ready);
endinterface

[src/pps_slot_mem.sv]
// ----------------------------------------------------------------------------
// Scheduler slot memory
// One write port and one read port with registered read data. A per-entry
// valid bit makes never-written slots read as all zero after reset.
// ----------------------------------------------------------------------------
module pps_slot_mem import pps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mem_req_type    mem_req,
   output slot_entry_type rd_data
);

   slot_entry_type       mem [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   slot_entry_type       rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[src/pps_ctrl.sv]
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Writes slots on load requests; on tick requests scans the slot memory one
// entry per cycle, keeps the best ready slot and writes back its new burst.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   pps_req_if.sink        req,
   output mem_req_type    mem_req,
   input  slot_entry_type rd_data,
   output logic           res_valid,
   input  logic           res_take,
   output result_type     res
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff;
   logic             cand_ff;
   logic [IDX_W-1:0] cand_idx_ff;
   logic             best_valid_ff;
   logic [IDX_W-1:0] best_idx_ff;
   slot_entry_type   best_ff;
   logic [TIME_W-1:0] time_ff;
   result_type       res_ff;

   logic             accept;
   logic             load_hit;
   logic             cand_ready;
   logic             cand_better;
   logic [TIME_W-1:0] time_next;
   logic [BURST_W-1:0] rem_dec;
   logic [TIME_W-1:0] tat;
   result_type       upd_res;

   assign accept   = req.valid && req.ready;
   assign load_hit = accept && (req.command == CMD_LOAD) && (int'(req.slot) < SLOTS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = (req.command == CMD_TICK) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req.ready       = 1'b0;
      res_valid       = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = best_idx_ff;
      mem_req.wr_data = best_ff;
      mem_req.wr_data.remaining = rem_dec;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready       = 1'b1;
            mem_req.wr_en   = load_hit;
            mem_req.wr_addr = IDX_W'(req.slot);
            mem_req.wr_data = '{remaining:  req.burst,
                                orig_burst: req.burst,
                                arrive:     req.arrival,
                                prio:       req.priority_req};
         end
         ST_SCAN:   mem_req.rd_en = 1'b1;
         ST_UPDATE: mem_req.wr_en = best_valid_ff;
         ST_DONE:   res_valid = 1'b1;
         default: begin
         end
      endcase
   end

   // A slot is ready when it has work left and has arrived. Only a strictly
   // better slot replaces the current best, so ties keep the lower slot.
   assign cand_ready  = (rd_data.remaining != '0) && (rd_data.arrive <= time_ff);
   assign cand_better = !best_valid_ff
                        || (rd_data.prio < best_ff.prio)
                        || ((rd_data.prio == best_ff.prio)
                            && (rd_data.arrive < best_ff.arrive));

   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;
   assign rem_dec   = best_ff.remaining - 1'b1;
   assign tat       = time_next - best_ff.arrive;

   always_comb begin
      upd_res          = '0;
      upd_res.time_now = time_next;
      upd_res.idle     = 1'b1;
      if (best_valid_ff) begin
         upd_res.selected = SLOT_W'(best_idx_ff);
         upd_res.idle     = 1'b0;
         if (rem_dec == '0) begin
            upd_res.finished   = 1'b1;
            upd_res.completion = time_next;
            upd_res.turnaround = tat;
            upd_res.waiting    = (tat >= TIME_W'(best_ff.orig_burst))
                                 ? tat - TIME_W'(best_ff.orig_burst) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         cand_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         time_ff       <= '0;
      end else begin
         state_ff <= state_in;
         cand_ff  <= (state_ff == ST_SCAN);
         if (state_ff == ST_IDLE) begin
            addr_ff       <= '0;
            best_valid_ff <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (cand_ff && cand_ready && cand_better) begin
            best_valid_ff <= 1'b1;
         end
         if (accept && (req.command == CMD_LOAD)) begin
            time_ff <= '0;
         end else if (state_ff == ST_UPDATE) begin
            time_ff <= time_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_idx_ff <= addr_ff;
      if (cand_ff && cand_ready && cand_better) begin
         best_ff     <= rd_data;
         best_idx_ff <= cand_idx_ff;
      end
      if (accept && (req.command == CMD_LOAD)) begin
         res_ff <= '{time_now: '0, selected: '0, idle: 1'b1, finished: 1'b0,
                     completion: '0, turnaround: '0, waiting: '0};
      end else if (state_ff == ST_UPDATE) begin
         res_ff <= upd_res;
      end
   end

   assign res = res_ff;

endmodule

[src/preemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Tick-driven priority scheduler over a memory of process slots.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: command 0 loads a slot (burst, arrival,
//   priority_req) and clears the time counter; command 1 advances one tick,
//   running the ready slot with the smallest priority (ties: earlier arrival,
//   then lower slot). rsp returns exactly one result per request.
//   A load request writes its slot and registers its result when it is
//   accepted. A tick request reads the slot memory one entry per cycle,
//   then passes the drain and update states, where it writes back the
//   chosen slot and registers its result; either result is then offered.
//   One request is in work at a time; the output register holds a result
//   while the receiver stalls, and the next request is accepted meanwhile.
//   A new result waits inside the block until the output register is free.
//   Reset clears the time counter and marks every slot empty at once;
//   no clearing pass is needed and requests are accepted right away.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req,
   pps_rsp_if.source rsp
);

   mem_req_type    mem_req;
   slot_entry_type rd_data;
   logic           res_valid;
   logic           res_take;
   result_type     res;
   logic           rsp_valid_ff;
   result_type     rsp_data_ff;

   pps_slot_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.time_now   = rsp_data_ff.time_now;
   assign rsp.selected   = rsp_data_ff.selected;
   assign rsp.idle       = rsp_data_ff.idle;
   assign rsp.finished   = rsp_data_ff.finished;
   assign rsp.completion = rsp_data_ff.completion;
   assign rsp.turnaround = rsp_data_ff.turnaround;
   assign rsp.waiting    = rsp_data_ff.waiting;

   // The sequencer never reads and writes the slot memory in the same cycle.
   a_mem_exclusive: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> !mem_req.rd_en)
      else $error("slot memory read and written in the same cycle");

   // A finished slot was run, and its times are ordered.
   a_finish_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.finished) |->
         (!rsp.idle && (rsp.completion >= rsp.turnaround)
          && (rsp.turnaround >= rsp.waiting)))
      else $error("inconsistent completion report");

   // A finished result stays offered until the output register takes it.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_take) |=> res_valid)
      else $error("result dropped before hand-over");

endmodule
